// ===== sv/mbps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants, types and register codes for the masked byte pattern
// scan unit.
// ----------------------------------------------------------------------------
package mbps_pkg;

    // Longest signature and longest scanned range, in bytes.
    localparam int PATTERN_MAX = 32;
    localparam int MAX_SCAN    = 1024 * 1024;

    // Field and register widths.
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 6;
    localparam int MASK_W    = 32;
    localparam int WORD_W    = 64;
    localparam int PAT_WORDS = 4;
    localparam int PAT_W     = PAT_WORDS * WORD_W;
    localparam int WIN_W     = PATTERN_MAX * BYTE_W;
    localparam int SEEN_W    = $clog2(MAX_SCAN + 1);
    localparam int OFFSET_W  = 20;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 3'd0,
        CFG_EXACT_MASK     = 3'd1,
        CFG_PATTERN_WORD_0 = 3'd2,
        CFG_PATTERN_WORD_1 = 3'd3,
        CFG_PATTERN_WORD_2 = 3'd4,
        CFG_PATTERN_WORD_3 = 3'd5
    } t_cfg_idx;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND      = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_TOO_SMALL  = 2'd2,
        ST_BAD_LENGTH = 2'd3
    } t_status;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [LEN_W-1:0]  pattern_length;
        logic [MASK_W-1:0] exact_mask;
        logic [PAT_W-1:0]  pattern;
    } t_cfg;

endpackage

// ===== sv/mbps_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_cfg_regs
// Configuration register file: pattern length, exact mask and the four
// signature words. Writes are always accepted; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module mbps_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mbps_pkg::WORD_W-1:0]          i_cfg_data,
    output mbps_pkg::t_cfg                       o_cfg
);

    mbps_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes, decoded by index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mbps_pkg::CFG_PATTERN_LENGTH: begin
                    r_cfg.pattern_length <= i_cfg_data[mbps_pkg::LEN_W-1:0];
                end
                mbps_pkg::CFG_EXACT_MASK: begin
                    r_cfg.exact_mask <= i_cfg_data[mbps_pkg::MASK_W-1:0];
                end
                mbps_pkg::CFG_PATTERN_WORD_0: begin
                    r_cfg.pattern[0*mbps_pkg::WORD_W +: mbps_pkg::WORD_W] <= i_cfg_data;
                end
                mbps_pkg::CFG_PATTERN_WORD_1: begin
                    r_cfg.pattern[1*mbps_pkg::WORD_W +: mbps_pkg::WORD_W] <= i_cfg_data;
                end
                mbps_pkg::CFG_PATTERN_WORD_2: begin
                    r_cfg.pattern[2*mbps_pkg::WORD_W +: mbps_pkg::WORD_W] <= i_cfg_data;
                end
                mbps_pkg::CFG_PATTERN_WORD_3: begin
                    r_cfg.pattern[3*mbps_pkg::WORD_W +: mbps_pkg::WORD_W] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== sv/mbps_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_window
// Shift line of the most recent bytes. Presents the window that includes the
// incoming byte, realigned so that signature byte i lines up with entry i.
// ----------------------------------------------------------------------------
module mbps_window (
    input  logic                              i_clk,
    input  logic                              i_shift,
    input  logic [mbps_pkg::BYTE_W-1:0]       i_byte,
    input  logic [mbps_pkg::LEN_W-1:0]        i_pattern_length,
    output logic [mbps_pkg::WIN_W-1:0]        o_aligned
);

    // Entry k holds the byte taken k items ago.
    logic [mbps_pkg::WIN_W-1:0] r_window;
    logic [mbps_pkg::WIN_W-1:0] n_window;
    logic [mbps_pkg::WIN_W-1:0] w_reversed;
    logic [mbps_pkg::LEN_W-1:0] w_skip;

    assign n_window = {r_window[mbps_pkg::WIN_W-mbps_pkg::BYTE_W-1:0], i_byte};

    // Oldest byte first, so that the window start sits at entry PATTERN_MAX-len.
    always_comb begin
        for (int j = 0; j < mbps_pkg::PATTERN_MAX; j++) begin
            w_reversed[j*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W] =
                n_window[(mbps_pkg::PATTERN_MAX-1-j)*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W];
        end
    end

    // Drop the unused older bytes; only meaningful for a valid length.
    assign w_skip    = mbps_pkg::LEN_W'(mbps_pkg::PATTERN_MAX) - i_pattern_length;
    assign o_aligned = w_reversed >> {w_skip, 3'b000};

    // Shift line, advanced once per counted item.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_window <= n_window;
        end
    end

endmodule

// ===== sv/mbps_sig_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_sig_cmp
// Masked parallel compare of the aligned window against the signature.
// Positions with a clear mask bit, or beyond the pattern length, always pass.
// ----------------------------------------------------------------------------
module mbps_sig_cmp (
    input  logic [mbps_pkg::WIN_W-1:0]   i_aligned,
    input  mbps_pkg::t_cfg               i_cfg,
    output logic                         o_match
);

    logic [mbps_pkg::PATTERN_MAX-1:0] w_pass;

    // One equality per signature position, then a reduction.
    always_comb begin
        for (int i = 0; i < mbps_pkg::PATTERN_MAX; i++) begin
            w_pass[i] = !(i_cfg.exact_mask[i]
                          && (mbps_pkg::LEN_W'(i) < i_cfg.pattern_length))
                        || (i_aligned[i*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W]
                            == i_cfg.pattern[i*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W]);
        end
    end

    assign o_match = &w_pass;

endmodule

// ===== sv/masked_byte_pattern_scan_unit.sv =====
`timescale 1ns / 1ps
// A result item is taken into the input register, then registered in the result register.
// Throughput: one input item per cycle while a held result is not stalled; the masked window
// compare is a single parallel stage between the input register and the result register.
// Reset (synchronous, active low) clears the configuration, the byte count, the
// reported flag and all valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_unit
// Wildcard byte signature search over a byte stream, reporting the offset of
// the first matching window, or a status at the last byte of the range.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_last_byte,
    // Result items
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_status,
    output logic [19:0]                         o_match_offset,
    // Configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mbps_pkg::WORD_W-1:0]         i_cfg_data
);

    mbps_pkg::t_cfg                  w_cfg;

    // Input register
    logic                            r_s1_valid;
    logic [mbps_pkg::BYTE_W-1:0]     r_s1_byte;
    logic                            r_s1_last;

    // Scan state
    logic [mbps_pkg::SEEN_W-1:0]     r_seen;
    logic                            r_reported;

    // Result register
    logic                            r_out_valid;
    mbps_pkg::t_status               r_status;
    logic [mbps_pkg::OFFSET_W-1:0]   r_offset;

    logic                            w_advance;
    logic                            w_accept;
    logic                            w_process;
    logic                            w_in_scan;
    logic                            w_len_ok;
    logic [mbps_pkg::SEEN_W-1:0]     n_seen;
    logic [mbps_pkg::SEEN_W-1:0]     w_len_ext;
    logic [mbps_pkg::SEEN_W-1:0]     w_start;
    logic [mbps_pkg::WIN_W-1:0]      w_aligned;
    logic                            w_match;
    logic                            w_hit;
    logic                            w_end_report;
    mbps_pkg::t_status               w_end_status;

    mbps_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Handshake: the pipeline moves whenever the result register can be refilled.
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_process  = r_s1_valid && w_advance;

    // Byte counting; bytes past the scan limit are neither counted nor compared.
    assign w_in_scan = r_seen < mbps_pkg::SEEN_W'(mbps_pkg::MAX_SCAN);
    assign n_seen    = w_in_scan ? r_seen + 1'b1 : r_seen;
    assign w_len_ext = mbps_pkg::SEEN_W'(w_cfg.pattern_length);
    assign w_start   = n_seen - w_len_ext;
    assign w_len_ok  = (w_cfg.pattern_length != '0)
                       && (w_cfg.pattern_length <= mbps_pkg::LEN_W'(mbps_pkg::PATTERN_MAX));

    mbps_window u_window (
        .i_clk            (i_clk),
        .i_shift          (w_process && w_in_scan),
        .i_byte           (r_s1_byte),
        .i_pattern_length (w_cfg.pattern_length),
        .o_aligned        (w_aligned)
    );

    mbps_sig_cmp u_sig_cmp (
        .i_aligned (w_aligned),
        .i_cfg     (w_cfg),
        .o_match   (w_match)
    );

    // First match in the range, and the closing status when nothing matched.
    assign w_hit        = w_in_scan && !r_reported && w_len_ok
                          && (n_seen >= w_len_ext) && w_match;
    assign w_end_report = r_s1_last && !r_reported && !w_hit;

    always_comb begin
        if (!w_len_ok) begin
            w_end_status = mbps_pkg::ST_BAD_LENGTH;
        end else if (n_seen < w_len_ext) begin
            w_end_status = mbps_pkg::ST_TOO_SMALL;
        end else begin
            w_end_status = mbps_pkg::ST_NOT_FOUND;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!r_s1_valid || w_advance) begin
            r_s1_valid <= w_accept;
        end
        if (w_accept) begin
            r_s1_byte <= i_data_byte;
            r_s1_last <= i_last_byte;
        end
    end

    // Scan state; the last byte of a range starts a fresh one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_reported <= 1'b0;
        end else if (w_process) begin
            if (r_s1_last) begin
                r_seen     <= '0;
                r_reported <= 1'b0;
            end else begin
                r_seen     <= n_seen;
                r_reported <= r_reported || w_hit;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_process && (w_hit || w_end_report);
        end
        if (w_process && w_hit) begin
            r_status <= mbps_pkg::ST_FOUND;
            r_offset <= mbps_pkg::OFFSET_W'(w_start);
        end else if (w_process && w_end_report) begin
            r_status <= w_end_status;
            r_offset <= '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_match_offset = r_offset;

endmodule

// ===== sim/mbps_result_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_result_check
// Watches the byte, result and register channels of the scan unit. It keeps
// its own copy of the configuration and of the scan state, works out the
// result that each accepted byte causes, and compares every accepted result
// field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module mbps_result_check
    import mbps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Byte items
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic                 i_last_byte,
    // Result items
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [STATUS_W-1:0]  i_status,
    input  logic [OFFSET_W-1:0]  i_match_offset,
    // Register writes
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    // Towards the testbench top
    output int                   o_error_count,
    output int                   o_pending
);

    typedef struct packed {
        t_status             status;
        logic [OFFSET_W-1:0] offset;
    } scan_report_t;

    // Predicted configuration.
    logic [LEN_W-1:0]  sig_len;
    logic [MASK_W-1:0] sig_mask;
    logic [WORD_W-1:0] sig_words [PAT_WORDS];

    // Predicted scan state: recent_bytes[k] is the byte taken k items ago.
    logic [BYTE_W-1:0] recent_bytes [PATTERN_MAX];
    logic [SEEN_W-1:0] byte_count;
    bit                match_reported;

    // Results still owed by the block, oldest first.
    scan_report_t      owed_reports [$];

    // Return the scan state to its start-of-range values.
    function automatic void clear_scan();
        for (int k = 0; k < PATTERN_MAX; k++) begin
            recent_bytes[k] = '0;
        end
        byte_count     = '0;
        match_reported = 1'b0;
    endfunction

    function automatic bit length_ok();
        return sig_len != 0 && sig_len <= PATTERN_MAX;
    endfunction

    // Masked compare of the window completed by the newest byte.
    function automatic bit window_hit();
        int unsigned age;
        logic [BYTE_W-1:0] want;
        for (int i = 0; i < sig_len; i++) begin
            age  = sig_len - 1 - i;
            want = sig_words[i / 8][(i % 8) * 8 +: 8];
            if (sig_mask[i] && recent_bytes[age] != want) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Apply one register write; unmapped indexes leave everything as it was.
    function automatic void take_register(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [WORD_W-1:0] value);
        case (idx)
            CFG_PATTERN_LENGTH: sig_len      = value[LEN_W-1:0];
            CFG_EXACT_MASK:     sig_mask     = value[MASK_W-1:0];
            CFG_PATTERN_WORD_0: sig_words[0] = value;
            CFG_PATTERN_WORD_1: sig_words[1] = value;
            CFG_PATTERN_WORD_2: sig_words[2] = value;
            CFG_PATTERN_WORD_3: sig_words[3] = value;
            default: ;
        endcase
    endfunction

    // Advance the scan by one byte and queue the result it causes, if any.
    function automatic void scan_byte(input logic [BYTE_W-1:0] b, input logic last);
        scan_report_t rep;
        // Bytes past the longest range are neither counted nor compared.
        if (byte_count < MAX_SCAN) begin
            for (int k = PATTERN_MAX - 1; k > 0; k--) begin
                recent_bytes[k] = recent_bytes[k - 1];
            end
            recent_bytes[0] = b;
            byte_count++;
            if (!match_reported && length_ok() && byte_count >= sig_len
                    && window_hit()) begin
                rep.status     = ST_FOUND;
                rep.offset     = OFFSET_W'(byte_count - sig_len);
                match_reported = 1'b1;
                owed_reports.push_back(rep);
            end
        end
        // The final byte reports only when nothing was found earlier.
        if (last) begin
            if (!match_reported) begin
                if (!length_ok()) begin
                    rep.status = ST_BAD_LENGTH;
                end else if (byte_count < sig_len) begin
                    rep.status = ST_TOO_SMALL;
                end else begin
                    rep.status = ST_NOT_FOUND;
                end
                rep.offset = '0;
                owed_reports.push_back(rep);
            end
            clear_scan();
        end
    endfunction

    // Observe all three channels at each rising edge.
    always @(posedge i_clk) begin
        int errs;
        scan_report_t want;
        errs = o_error_count;
        if (!i_rst_n) begin
            sig_len  = '0;
            sig_mask = '0;
            for (int w = 0; w < PAT_WORDS; w++) begin
                sig_words[w] = '0;
            end
            clear_scan();
            owed_reports.delete();
            errs = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                take_register(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && !i_in_stall) begin
                scan_byte(i_data_byte, i_last_byte);
            end
            // Each accepted result is held against the oldest owed one.
            if (i_out_valid && !i_out_stall) begin
                if (owed_reports.size() == 0) begin
                    errs++;
                    $display("%0t: unexpected result, status %0d offset %0d",
                             $time, i_status, i_match_offset);
                end else begin
                    want = owed_reports.pop_front();
                    if (i_status !== want.status) begin
                        errs++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, i_status);
                    end
                    if (i_match_offset !== want.offset) begin
                        errs++;
                        $display("%0t: match_offset expected %0d, got %0d",
                                 $time, want.offset, i_match_offset);
                    end
                end
            end
        end
        o_error_count <= errs;
        o_pending     <= owed_reports.size();
    end

endmodule

// ===== sim/masked_byte_pattern_scan_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_unit_tb
// Drives byte ranges and register writes into the scan unit. A short directed
// sequence covers the status codes, exact-length and offset matches, wildcard
// positions and a register change inside a range; random phases then vary the
// signature and send ranges with planted matches and near misses, under
// random gaps and result stalls. The checker beside the block predicts and
// compares; this module reports the verdict.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan_unit_tb;
    import mbps_pkg::*;

    localparam int CLK_PERIOD     = 2;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 1450;
    localparam int DRAIN_CYCLES   = 4;
    localparam int END_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // Indexes past the register map, which the block must ignore.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_data_byte    = '0;
    logic                 i_last_byte    = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall    = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [OFFSET_W-1:0]  o_match_offset;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [WORD_W-1:0]    i_cfg_data     = '0;

    int error_count;
    int pending;

    // Signature in force, used to build matching ranges.
    logic [LEN_W-1:0]  cfg_len   = '0;
    logic [MASK_W-1:0] cfg_mask  = '0;
    logic [WORD_W-1:0] cfg_words [PAT_WORDS];

    bit          quiet_mode  = 1'b0;
    int          items_sent  = 0;
    int          idle_cycles = 0;
    int unsigned stall_run   = 0;

    masked_byte_pattern_scan_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_match_offset (o_match_offset),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    mbps_result_check u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_status       (o_status),
        .i_match_offset (o_match_offset),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_error_count  (error_count),
        .o_pending      (pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Idle length: mostly short, sometimes medium, rarely long.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) begin
            return $urandom_range(1, 3);
        end else if (r < 19) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [BYTE_W-1:0] sig_byte(input int i);
        return cfg_words[i / 8][(i % 8) * 8 +: 8];
    endfunction

    // Background bytes: some are signature bytes, to give near misses.
    function automatic logic [BYTE_W-1:0] filler_byte();
        if ($urandom_range(0, 2) == 0) begin
            return sig_byte($urandom_range(0, PATTERN_MAX - 1));
        end
        return 8'($urandom);
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return LEN_W'($urandom_range(PATTERN_MAX + 1, 63));
        end else if (r < 5) begin
            return LEN_W'($urandom_range(9, PATTERN_MAX));
        end
        return LEN_W'($urandom_range(1, 8));
    endfunction

    function automatic logic [MASK_W-1:0] pick_mask();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r < 4) begin
            return '1;
        end
        return $urandom;
    endfunction

    // Ranges are mostly long enough to hold a window; some are shorter.
    function automatic int pick_range_len();
        if (cfg_len == 0 || cfg_len > PATTERN_MAX) begin
            return $urandom_range(1, 8);
        end
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(1, cfg_len);
        end
        return $urandom_range(cfg_len, cfg_len + 12);
    endfunction

    // Result stalls: runs of random length, none while in quiet mode.
    always @(posedge i_clk) begin
        if (stall_run != 0) begin
            stall_run--;
        end else if (quiet_mode || $urandom_range(0, 1) == 0) begin
            i_out_stall <= 1'b0;
            stall_run = $urandom_range(0, 12);
        end else begin
            i_out_stall <= 1'b1;
            stall_run = idle_length();
        end
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("masked_byte_pattern_scan_unit_tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one byte item, sometimes after a random gap, and hold it until accepted.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = 0;
        if (!quiet_mode && $urandom_range(0, 1) == 0) begin
            gap = idle_length();
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Send a short range given low byte first, marking its final byte.
    task automatic send_bytes(input logic [63:0] seq, input int count);
        for (int k = 0; k < count; k++) begin
            send_byte(seq[k * 8 +: 8], k == count - 1);
        end
    endtask

    // Wait for every owed result, then for the pipeline to empty.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Present one register write; the caller lowers valid after the batch.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [WORD_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Load a whole signature once the block is idle.
    task automatic set_config(input logic [LEN_W-1:0] len, input logic [MASK_W-1:0] mask,
                              input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
                              input logic [WORD_W-1:0] w2, input logic [WORD_W-1:0] w3);
        wait_idle();
        cfg_len      = len;
        cfg_mask     = mask;
        cfg_words[0] = w0;
        cfg_words[1] = w1;
        cfg_words[2] = w2;
        cfg_words[3] = w3;
        write_reg(CFG_PATTERN_LENGTH, WORD_W'(len));
        write_reg(CFG_EXACT_MASK, WORD_W'(mask));
        write_reg(CFG_PATTERN_WORD_0, w0);
        write_reg(CFG_PATTERN_WORD_1, w1);
        write_reg(CFG_PATTERN_WORD_2, w2);
        write_reg(CFG_PATTERN_WORD_3, w3);
        if ($urandom_range(0, 3) == 0) begin
            write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, rand_word());
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Build a range, optionally plant the signature in it, and send it.
    // An open range carries no final flag and runs on into the next phase.
    task automatic send_range(input int len, input bit plant, input bit close);
        logic [BYTE_W-1:0] range_bytes [$];
        int at;
        for (int k = 0; k < len; k++) begin
            range_bytes.push_back(filler_byte());
        end
        if (plant && cfg_len != 0 && cfg_len <= PATTERN_MAX && len >= cfg_len) begin
            at = $urandom_range(0, len - cfg_len);
            for (int i = 0; i < cfg_len; i++) begin
                if (cfg_mask[i]) begin
                    range_bytes[at + i] = sig_byte(i);
                end
            end
        end
        for (int k = 0; k < len; k++) begin
            send_byte(range_bytes[k], close && k == len - 1);
        end
    endtask

    initial begin
        int phase;
        int ranges;
        for (int w = 0; w < PAT_WORDS; w++) begin
            cfg_words[w] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero length straight after reset, then a length above the maximum.
        send_bytes(64'h00, 1);
        set_config(6'd63, '0, '0, '0, '0, '0);
        send_bytes(64'hFF, 1);

        // Four-byte signature with a wildcard in its third position.
        set_config(6'd4, 32'h0000_000B, 64'hDDCC_BBAA, '0, '0, '0);
        send_bytes(64'hCC_BBAA, 3);
        send_bytes(64'hDD55_BBAA, 4);
        send_bytes(64'h11_DDCC_BBAA_00, 6);
        send_bytes(64'hDECC_BBAA, 4);

        // One-byte signature, then a change of signature inside a range.
        set_config(6'd1, 32'h1, 64'hFF, '0, '0, '0);
        send_bytes(64'hFF, 1);
        send_bytes(64'h00, 1);
        send_byte(8'h00, 1'b0);
        set_config(6'd1, 32'h1, 64'h00, '0, '0, '0);
        send_byte(8'h00, 1'b1);

        // Random phases: a fresh signature, then several ranges.
        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case (phase)
                0: set_config(6'd32, '1, '1, '1, '1, '1);
                1: set_config(6'd32, '0, '0, '0, '0, '0);
                2: set_config(6'd33, $urandom, rand_word(), rand_word(), rand_word(),
                              rand_word());
                default: set_config(pick_len(), pick_mask(), rand_word(), rand_word(),
                                    rand_word(), rand_word());
            endcase
            quiet_mode = ($urandom_range(0, 3) == 0);
            ranges     = $urandom_range(3, 8);
            for (int r = 0; r < ranges; r++) begin
                if ($urandom_range(0, 29) == 0) begin
                    wait_idle();
                end
                send_range(pick_range_len(), $urandom_range(0, 9) < 6, 1'b1);
            end
            if ($urandom_range(0, 4) == 0) begin
                send_range($urandom_range(1, 6), 1'b0, 1'b0);
            end
            phase++;
        end

        wait_idle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending == 0) begin
            $display("masked_byte_pattern_scan_unit_tb: clean");
        end else begin
            $display("masked_byte_pattern_scan_unit_tb: errors");
        end
        $finish;
    end

endmodule
